// File: design/sptq_pkg.sv
// Shared types and codes for the sorted priority task queue.
package sptq_pkg;

  // Operation codes carried by an input transaction.
  typedef enum logic {
    FUNC_ADD = 1'b0,
    FUNC_POP = 1'b1
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_PUT,
    S_POP_HEAD,
    S_POP_SHIFT
  } state_t;

  // One queue slot.
  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] hdl;
  } entry_t;

endpackage

// File: design/sptq_in_if.sv
// Input channel interface: one operation per transaction.
interface sptq_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  task_priority;
  logic [15:0] task_handle;

  modport source (output valid, output func, output task_priority, output task_handle,
                  input ready);
  modport sink (input valid, input func, input task_priority, input task_handle,
                output ready);
endinterface

// File: design/sptq_out_if.sv
// Result channel interface: one result per transaction.
interface sptq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_handle;
  logic [7:0]  out_priority;
  logic [4:0]  entry_count;

  modport source (output valid, output status, output out_handle, output out_priority,
                  output entry_count, input ready);
  modport sink (input valid, input status, input out_handle, input out_priority,
                input entry_count, output ready);
endinterface

// File: design/sptq_mem.sv
// Slot store: one write port and one registered read port.
module sptq_mem #(
  parameter int QUEUE_DEPTH = 16,
  localparam int IW = $clog2(QUEUE_DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IW-1:0]   waddr,
  input  sptq_pkg::entry_t wdata,
  input  logic [IW-1:0]   raddr,
  output sptq_pkg::entry_t rdata
);
  import sptq_pkg::*;

  entry_t mem_r [QUEUE_DEPTH];
  entry_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/sptq_ctrl.sv
// Sequencer: scans and shifts the slot store one entry per cycle.
module sptq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  localparam int IW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  sptq_in_if.sink          in_chan,
  sptq_out_if.source       out_chan,
  output logic             mem_we,
  output logic [IW-1:0]    mem_waddr,
  output sptq_pkg::entry_t mem_wdata,
  output logic [IW-1:0]    mem_raddr,
  input  sptq_pkg::entry_t mem_rdata
);
  import sptq_pkg::*;

  state_t        state_r, state_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  entry_t        new_r, new_nxt;
  entry_t        head_r, head_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  entry_t        out_entry_r, out_entry_nxt;
  logic [4:0]    out_count_r, out_count_nxt;

  logic          accept;
  logic          done;
  status_t       res_status;
  entry_t        res_entry;
  logic [IW-1:0] last_idx;
  logic [CW+4:0] occ_ext;

  assign in_chan.ready = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;
  assign last_idx      = IW'(occ_r - CW'(1));

  // Next state, store access and result selection.
  always_comb begin
    state_nxt  = state_r;
    occ_nxt    = occ_r;
    idx_nxt    = idx_r;
    new_nxt    = new_r;
    head_nxt   = head_r;
    mem_we     = 1'b0;
    mem_waddr  = IW'(idx_r + IW'(1));
    mem_wdata  = mem_rdata;
    mem_raddr  = '0;
    done       = 1'b0;
    res_status = ST_ADDED;
    res_entry  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          new_nxt.prio = in_chan.task_priority;
          new_nxt.hdl  = in_chan.task_handle;
          if (func_t'(in_chan.func) == FUNC_ADD) begin
            if (occ_r == CW'(QUEUE_DEPTH)) begin
              done       = 1'b1;
              res_status = ST_FULL;
            end else if (occ_r == '0) begin
              state_nxt = S_ADD_PUT;
            end else begin
              mem_raddr = last_idx;
              idx_nxt   = last_idx;
              state_nxt = S_ADD_SCAN;
            end
          end else begin
            if (occ_r == '0) begin
              done       = 1'b1;
              res_status = ST_EMPTY;
            end else begin
              mem_raddr = '0;
              state_nxt = S_POP_HEAD;
            end
          end
        end
      end
      S_ADD_SCAN: begin
        // Entries at or above the new priority move up one slot.
        mem_raddr = IW'(idx_r - IW'(1));
        mem_we    = 1'b1;
        mem_waddr = IW'(idx_r + IW'(1));
        if (mem_rdata.prio >= new_r.prio) begin
          mem_wdata = mem_rdata;
          if (idx_r == '0) begin
            state_nxt = S_ADD_PUT;
          end else begin
            idx_nxt = IW'(idx_r - IW'(1));
          end
        end else begin
          mem_wdata  = new_r;
          done       = 1'b1;
          res_status = ST_ADDED;
          occ_nxt    = CW'(occ_r + CW'(1));
          state_nxt  = S_IDLE;
        end
      end
      S_ADD_PUT: begin
        // New entry becomes the head.
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = new_r;
        done       = 1'b1;
        res_status = ST_ADDED;
        occ_nxt    = CW'(occ_r + CW'(1));
        state_nxt  = S_IDLE;
      end
      S_POP_HEAD: begin
        head_nxt  = mem_rdata;
        mem_raddr = IW'(1);
        idx_nxt   = IW'(1);
        if (occ_r == CW'(1)) begin
          done       = 1'b1;
          res_status = ST_POPPED;
          res_entry  = mem_rdata;
          occ_nxt    = CW'(occ_r - CW'(1));
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_POP_SHIFT;
        end
      end
      S_POP_SHIFT: begin
        // Each remaining entry moves down one slot.
        mem_we    = 1'b1;
        mem_waddr = IW'(idx_r - IW'(1));
        mem_wdata = mem_rdata;
        if (idx_r == last_idx) begin
          done       = 1'b1;
          res_status = ST_POPPED;
          res_entry  = head_r;
          occ_nxt    = CW'(occ_r - CW'(1));
          state_nxt  = S_IDLE;
        end else begin
          mem_raddr = IW'(idx_r + IW'(1));
          idx_nxt   = IW'(idx_r + IW'(1));
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register loads on completion and clears when the result is taken.
  assign occ_ext = {5'd0, occ_nxt};

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_count_nxt  = out_count_r;
    if (done) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_entry_nxt  = res_entry;
      out_count_nxt  = occ_ext[4:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    new_r        <= new_nxt;
    head_r       <= head_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.out_handle   = out_entry_r.hdl;
  assign out_chan.out_priority = out_entry_r.prio;
  assign out_chan.entry_count  = out_count_r;

endmodule

// File: design/sorted_priority_task_queue_core.sv
// Add: scan from the tail moving entries up, then write; pop: read head, shift rest down.
// Full adds and empty pops finish in the accept cycle; the result shows the cycle after.
// One operation at a time; walking the slot store one entry per cycle sets the rate.
// A new operation is taken only while the output register is empty or being read.
// Synchronous reset empties the queue; slot contents stay undefined and need no clearing.
module sorted_priority_task_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  sptq_in_if.sink    in_chan,
  sptq_out_if.source out_chan
);
  import sptq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [IW-1:0] mem_raddr;
  entry_t        mem_rdata;

  // Sequencer.
  sptq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Slot store.
  sptq_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: test/sorted_priority_task_queue_core_tb.sv
// Self-checking testbench for the sorted priority task queue core.
module sorted_priority_task_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sptq_pkg::*;

  localparam int QUEUE_DEPTH    = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_PER_PHASE = 160;

  // Idle profiles of the run.
  typedef enum int {
    PH_NO_IDLE,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH_IDLE
  } idle_phase_t;

  // One predicted result transaction.
  typedef struct {
    status_t     status;
    logic [15:0] hdl;
    logic [7:0]  prio;
    logic [4:0]  count;
  } queue_result_t;

  // Keeps a shadow of the sorted queue and the results it predicts.
  class sptq_scoreboard;
    entry_t        shadow_slots[QUEUE_DEPTH];
    int unsigned   shadow_fill;
    queue_result_t pending_results[$];
    int unsigned   errors;

    function new();
      shadow_fill = 0;
      errors      = 0;
    endfunction

    // Apply one accepted operation to the shadow queue and queue its result.
    function void note_op(func_t op, logic [7:0] prio, logic [15:0] hdl);
      queue_result_t r;
      int unsigned   pos;
      r.hdl  = '0;
      r.prio = '0;
      if (op == FUNC_ADD) begin
        if (shadow_fill >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // New entry goes ahead of the first one with equal or higher priority.
          pos = shadow_fill;
          for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_slots[i].prio >= prio) begin
              pos = i;
              break;
            end
          end
          for (int i = shadow_fill; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[pos].prio = prio;
          shadow_slots[pos].hdl  = hdl;
          shadow_fill++;
          r.status = ST_ADDED;
        end
      end else if (shadow_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_POPPED;
        r.hdl    = shadow_slots[0].hdl;
        r.prio   = shadow_slots[0].prio;
        for (int i = 1; i < shadow_fill; i++) shadow_slots[i-1] = shadow_slots[i];
        shadow_fill--;
      end
      r.count = shadow_fill[4:0];
      pending_results.push_back(r);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(logic [1:0] status, logic [15:0] hdl, logic [7:0] prio,
                               logic [4:0] count);
      queue_result_t r;
      if (pending_results.size() == 0) begin
        $error("result with no prediction: status=%0d handle=%h priority=%0d count=%0d",
               status, hdl, prio, count);
        errors++;
        return;
      end
      r = pending_results.pop_front();
      if (status !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, status);
        errors++;
      end
      if (hdl !== r.hdl) begin
        $error("out_handle: expected %h, actual %h", r.hdl, hdl);
        errors++;
      end
      if (prio !== r.prio) begin
        $error("out_priority: expected %0d, actual %0d", r.prio, prio);
        errors++;
      end
      if (count !== r.count) begin
        $error("entry_count: expected %0d, actual %0d", r.count, count);
        errors++;
      end
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  idle_phase_t idle_phase;
  sptq_scoreboard sb;

  sptq_in_if  in_chan();
  sptq_out_if out_chan();

  sorted_priority_task_queue_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Clock: 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned sender_idle_pct();
    case (idle_phase)
      PH_SENDER_IDLE: return 57;
      PH_BOTH_IDLE:   return 19;
      default:        return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case (idle_phase)
      PH_RECEIVER_STALL: return 57;
      PH_BOTH_IDLE:      return 19;
      default:           return 0;
    endcase
  endfunction

  // Receiver back-pressure, updated on the falling edge.
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
  end

  // Observe both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        sb.note_op(func_t'(in_chan.func), in_chan.task_priority, in_chan.task_handle);
      if (out_chan.valid && out_chan.ready)
        sb.check_result(out_chan.status, out_chan.out_handle, out_chan.out_priority,
                        out_chan.entry_count);
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_n);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Drive one operation and return at the edge where it is accepted.
  task automatic send_op(input func_t op, input logic [7:0] prio, input logic [15:0] hdl);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.func          <= op;
    in_chan.task_priority <= prio;
    in_chan.task_handle   <= hdl;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Hold the sender off until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  // Random mix in bursts: add-heavy, pop-heavy or balanced, wide or narrow priorities.
  task automatic run_random(input int unsigned n_items);
    int unsigned add_pct;
    int unsigned prio_max;
    func_t       op;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 20 == 0) begin
        case ($urandom_range(0, 2))
          0:       add_pct = 80;
          1:       add_pct = 25;
          default: add_pct = 50;
        endcase
        prio_max = ($urandom_range(0, 1) == 0) ? 3 : 255;
      end
      op = ($urandom_range(0, 99) < add_pct) ? FUNC_ADD : FUNC_POP;
      send_op(op, 8'($urandom_range(0, prio_max)), 16'($urandom()));
    end
  endtask

  // Main sequence.
  initial begin
    sb         = new();
    idle_phase = PH_NO_IDLE;
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.func          = FUNC_ADD;
    in_chan.task_priority = '0;
    in_chan.task_handle   = '0;
    out_chan.ready        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: pop on an empty queue, extremes, ties, fill to full, add when full.
    send_op(FUNC_POP, 8'hFF, 16'hFFFF);
    send_op(FUNC_ADD, 8'd7, 16'h1111);
    send_op(FUNC_ADD, 8'd7, 16'h2222);
    send_op(FUNC_ADD, 8'd0, 16'h0000);
    send_op(FUNC_ADD, 8'd255, 16'hFFFF);
    send_op(FUNC_ADD, 8'd3, 16'hA5A5);
    for (int i = 0; i < QUEUE_DEPTH - 5; i++)
      send_op(FUNC_ADD, 8'((i * 23) % 256), 16'h5A00 + 16'(i));
    send_op(FUNC_ADD, 8'd0, 16'hBEEF);
    repeat (4) send_op(FUNC_POP, 8'h00, 16'h0000);
    wait_drained();

    // Random phases over every idle profile, drained in between.
    for (int ph = PH_NO_IDLE; ph <= PH_BOTH_IDLE; ph++) begin
      idle_phase = idle_phase_t'(ph);
      run_random(RANDOM_PER_PHASE);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/sptq_pkg.sv
design/sptq_in_if.sv
design/sptq_out_if.sv
design/sptq_mem.sv
design/sptq_ctrl.sv
design/sorted_priority_task_queue_core.sv
test/sorted_priority_task_queue_core_tb.sv
